// File: hdl/tmc_pkg.sv
package tmc_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_WAIT   = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NO_SPACE  = 3'd1,
    STAT_INVALID   = 3'd2,
    STAT_CANCELED  = 3'd3,
    STAT_FINISHED  = 3'd4,
    STAT_RUNNING   = 3'd5,
    STAT_FIRED     = 3'd6,
    STAT_NONE      = 3'd7
  } status_t;

  // slot modes
  localparam logic [1:0] MODE_RUNNING  = 2'd1;
  localparam logic [1:0] MODE_CANCELED = 2'd2;
  localparam logic [1:0] MODE_FINISHED = 2'd3;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DONE
  } fsm_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  job_id;
    logic [15:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] job_slot;
    logic       last;
  } out_item_t;

  // what the head stage saw in the slot passing by
  typedef struct packed {
    logic    alloc;
    logic    fire;
    logic    hit;
    status_t hit_status;
  } head_evt_t;

endpackage

// File: hdl/tmc_cell.sv
module tmc_cell import tmc_pkg::*; #(
  parameter int DELAY_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift_en,
  input  logic                  d_used,
  input  logic [1:0]            d_mode,
  input  logic [DELAY_BITS-1:0] d_ticks,
  output logic                  q_used,
  output logic [1:0]            q_mode,
  output logic [DELAY_BITS-1:0] q_ticks
);

  // occupancy is control state, mode and count are payload
  always_ff @(posedge clk) begin
    if (rst) begin
      q_used <= 1'b0;
    end else if (shift_en) begin
      q_used <= d_used;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_mode  <= d_mode;
      q_ticks <= d_ticks;
    end
  end

endmodule

// File: hdl/tmc_head.sv
module tmc_head import tmc_pkg::*; #(
  parameter int DELAY_BITS = 16
) (
  input  req_t                  req,
  input  logic                  id_match,
  input  logic                  found,
  input  logic [DELAY_BITS-1:0] delay_ld,
  input  logic                  q_used,
  input  logic [1:0]            q_mode,
  input  logic [DELAY_BITS-1:0] q_ticks,
  output logic                  n_used,
  output logic [1:0]            n_mode,
  output logic [DELAY_BITS-1:0] n_ticks,
  output head_evt_t             evt
);

  logic [DELAY_BITS-1:0] ticks_dec;

  assign ticks_dec = q_ticks - DELAY_BITS'(1);

  always_comb begin
    n_used         = q_used;
    n_mode         = q_mode;
    n_ticks        = q_ticks;
    evt.alloc      = 1'b0;
    evt.fire       = 1'b0;
    evt.hit        = 1'b0;
    evt.hit_status = STAT_OK;
    case (req)
      REQ_ADD: begin
        // lowest free slot takes the new timer
        if (!q_used && !found) begin
          n_used    = 1'b1;
          n_mode    = MODE_RUNNING;
          n_ticks   = delay_ld;
          evt.alloc = 1'b1;
        end
      end
      REQ_TICK: begin
        if (q_used && q_mode == MODE_RUNNING) begin
          n_ticks = ticks_dec;
          if (ticks_dec == '0) begin
            n_mode   = MODE_FINISHED;
            evt.fire = 1'b1;
          end
        end
      end
      REQ_CANCEL: begin
        if (id_match && q_used) begin
          evt.hit = 1'b1;
          if (q_mode == MODE_CANCELED) begin
            evt.hit_status = STAT_CANCELED;
          end else if (q_mode == MODE_FINISHED) begin
            evt.hit_status = STAT_FINISHED;
          end else begin
            n_mode = MODE_CANCELED;
          end
        end
      end
      REQ_WAIT: begin
        if (id_match && q_used) begin
          evt.hit = 1'b1;
          if (q_mode == MODE_RUNNING) begin
            evt.hit_status = STAT_RUNNING;
          end else begin
            n_used = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/multi_slot_countdown_timer_table_core.sv
// results: a transaction's result (or its last result) is registered once the slot sweep ends;
//   tick results come out one per fired slot, all but the last during the sweep
// flow: no request is taken until the previous one is done; the slot ring rotates once per request,
//   one slot through the head stage per cycle unless a fire waits on a held output register
// reset: synchronous; all slots are freed in the same cycle, no clearing sweep
module multi_slot_countdown_timer_table_core import tmc_pkg::*; #(
  parameter int NUM_SLOTS  = 64,
  parameter int DELAY_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int KW = $clog2(NUM_SLOTS);
  localparam int WB = (DELAY_BITS > 16) ? DELAY_BITS : 16;

  // ring of slot cells: cell 0 is the head, the head's update feeds the tail
  logic                  used_q  [NUM_SLOTS];
  logic [1:0]            mode_q  [NUM_SLOTS];
  logic [DELAY_BITS-1:0] ticks_q [NUM_SLOTS];

  logic                  head_used;
  logic [1:0]            head_mode;
  logic [DELAY_BITS-1:0] head_ticks;
  head_evt_t             evt;

  // request captured at acceptance
  req_t                  req;
  logic [5:0]            id_q;
  logic [DELAY_BITS-1:0] delay_q;

  fsm_t                  state;
  fsm_t                  state_next;
  logic [KW-1:0]         k;          // slot index now sitting in the head cell
  logic                  shift_en;
  logic                  scan_end;
  logic                  emit_final;
  logic                  stall;
  logic                  out_free;

  // running result for single-result requests
  status_t               res_status;
  logic [5:0]            res_slot;

  // newest fired slot of a tick, held back until we know whether it is the last one
  logic                  pend_valid;
  logic [5:0]            pend_slot;

  // delay preprocessing: saturate to the count width, zero counts as one tick
  logic [WB-1:0]         delay_wide;
  logic [DELAY_BITS-1:0] delay_sat;
  logic [DELAY_BITS-1:0] delay_ld;

  assign delay_wide = WB'(in_item.delay_ticks);
  assign delay_sat  = (delay_wide > WB'({DELAY_BITS{1'b1}})) ? {DELAY_BITS{1'b1}}
                                                             : DELAY_BITS'(delay_wide);
  assign delay_ld   = (delay_sat == '0) ? DELAY_BITS'(1) : delay_sat;

  genvar gi;
  generate
    for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_ring
      if (gi == NUM_SLOTS - 1) begin : g_tail
        tmc_cell #(.DELAY_BITS(DELAY_BITS)) u_cell (
          .clk      (clk),
          .rst      (rst),
          .shift_en (shift_en),
          .d_used   (head_used),
          .d_mode   (head_mode),
          .d_ticks  (head_ticks),
          .q_used   (used_q[gi]),
          .q_mode   (mode_q[gi]),
          .q_ticks  (ticks_q[gi])
        );
      end else begin : g_body
        tmc_cell #(.DELAY_BITS(DELAY_BITS)) u_cell (
          .clk      (clk),
          .rst      (rst),
          .shift_en (shift_en),
          .d_used   (used_q[gi+1]),
          .d_mode   (mode_q[gi+1]),
          .d_ticks  (ticks_q[gi+1]),
          .q_used   (used_q[gi]),
          .q_mode   (mode_q[gi]),
          .q_ticks  (ticks_q[gi])
        );
      end
    end
  endgenerate

  // head stage applies the pending request to the slot passing by
  tmc_head #(.DELAY_BITS(DELAY_BITS)) u_head (
    .req      (req),
    .id_match (id_q == 6'(k)),
    .found    (res_status == STAT_OK),
    .delay_ld (delay_q),
    .q_used   (used_q[0]),
    .q_mode   (mode_q[0]),
    .q_ticks  (ticks_q[0]),
    .n_used   (head_used),
    .n_mode   (head_mode),
    .n_ticks  (head_ticks),
    .evt      (evt)
  );

  assign out_free = !out_valid || out_ready;
  assign scan_end = (k == KW'(NUM_SLOTS - 1));
  // a second fire needs the output register for the held-back one
  assign stall    = evt.fire && pend_valid && !out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (in_valid) begin
          state_next = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (!stall && scan_end) begin
          state_next = FSM_DONE;
        end
      end
      FSM_DONE: begin
        if (out_free) begin
          state_next = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    shift_en   = 1'b0;
    emit_final = 1'b0;
    case (state)
      FSM_IDLE: begin
        in_ready = 1'b1;
      end
      FSM_SCAN: begin
        shift_en = !stall;
      end
      FSM_DONE: begin
        emit_final = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      if (shift_en) begin
        k <= scan_end ? '0 : k + KW'(1);
      end
    end
  end

  // request capture and running result
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req     <= req_t'(in_item.req_type);
      id_q    <= in_item.job_id;
      delay_q <= delay_ld;
      if (req_t'(in_item.req_type) == REQ_ADD) begin
        res_status <= STAT_NO_SPACE;
        res_slot   <= '0;
      end else begin
        res_status <= STAT_INVALID;
        res_slot   <= in_item.job_id;
      end
    end else if (shift_en && evt.alloc) begin
      res_status <= STAT_OK;
      res_slot   <= 6'(k);
    end else if (shift_en && evt.hit) begin
      res_status <= evt.hit_status;
      res_slot   <= 6'(k);
    end
  end

  // held-back fired slot
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (shift_en && evt.fire) begin
      pend_valid <= 1'b1;
    end else if (emit_final) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en && evt.fire) begin
      pend_slot <= 6'(k);
    end
  end

  // output register: a fire pushes out the previous one with last clear,
  // the end of the sweep pushes the final transaction with last set
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((shift_en && evt.fire && pend_valid) || emit_final) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en && evt.fire && pend_valid) begin
      out_item.status   <= STAT_FIRED;
      out_item.job_slot <= pend_slot;
      out_item.last     <= 1'b0;
    end else if (emit_final) begin
      out_item.last <= 1'b1;
      if (req == REQ_TICK) begin
        if (pend_valid) begin
          out_item.status   <= STAT_FIRED;
          out_item.job_slot <= pend_slot;
        end else begin
          out_item.status   <= STAT_NONE;
          out_item.job_slot <= '0;
        end
      end else begin
        out_item.status   <= res_status;
        out_item.job_slot <= res_slot;
      end
    end
  end

  // between requests the ring sits aligned and nothing is held back
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_IDLE) |-> (!pend_valid && k == '0))
    else $error("ring misaligned or fired slot left over while idle");

  // the ring only halts for a full output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_SCAN && !shift_en) |-> (out_valid && !out_ready))
    else $error("ring stalled without output back-pressure");

  // the final transaction always lands in the output register
  a_final_out: assert property (@(posedge clk) disable iff (rst)
    emit_final |=> (out_valid && out_item.last && state == FSM_IDLE))
    else $error("final transaction not presented");

  // non-tick requests never fire or hold back a slot
  a_no_fire: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_SCAN && req != REQ_TICK) |-> (!evt.fire && !pend_valid))
    else $error("fire outside a tick");

endmodule
